>>> rtl/urdf_pkg.sv
// Shared types, codes and the CRC-8 byte update for the UART register datagram framer.
// No dependencies; imported by the interfaces and every RTL module.
`default_nettype none

package urdf_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned REG_IDX_W = 7;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned COUNT_W   = 3;
    localparam int unsigned CFG_IDX_W = 1;
    // Sync, node, address and four data bytes; the CRC is not shifted
    localparam int unsigned FRAME_W   = 7 * BYTE_W;

    localparam logic [BYTE_W-1:0]  CRC_POLY      = 8'h07;
    localparam logic [BYTE_W-1:0]  SYNC_RESET    = 8'h05;
    localparam logic [BYTE_W-1:0]  NODE_RESET    = 8'h00;
    localparam logic [COUNT_W-1:0] READ_LAST_IX  = 3'd3;
    localparam logic [COUNT_W-1:0] WRITE_LAST_IX = 3'd7;

    // Command field codes
    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_command;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ADDRESS = 1'b0,
        CFG_SYNC_BYTE    = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SEND = 1'b1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic last;
    } t_dp_sts;

    // Fold one byte into the CRC, least significant bit first
    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data_in
    );
        logic [BYTE_W-1:0] crc;
        logic              fb;
        crc = crc_in;
        for (int j = 0; j < BYTE_W; j++) begin
            fb  = crc[BYTE_W-1] ^ data_in[j];
            crc = {crc[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

>>> rtl/urdf_cmd_if.sv
// Request channel: valid/ready transaction carrying one datagram request.
// Depends on urdf_pkg for field widths.
`default_nettype none

interface urdf_cmd_if
    import urdf_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [REG_IDX_W-1:0] register_index;
    logic [DATA_W-1:0]    write_data;

    modport source (output valid, command, register_index, write_data, input ready);
    modport sink   (input valid, command, register_index, write_data, output ready);
endinterface

`default_nettype wire

>>> rtl/urdf_byte_if.sv
// Byte channel: valid/ready transaction carrying one datagram byte and its last flag.
// Depends on urdf_pkg for field widths.
`default_nettype none

interface urdf_byte_if
    import urdf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] tx_byte;
    logic              last_byte;

    modport source (output valid, tx_byte, last_byte, input ready);
    modport sink   (input valid, tx_byte, last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/urdf_datapath.sv
// Datapath: configuration registers, frame shift register, byte counter, running CRC
// and output register. Depends on urdf_pkg.
`default_nettype none

module urdf_datapath
    import urdf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,
    input  wire logic                 i_command,
    input  wire logic [REG_IDX_W-1:0] i_register_index,
    input  wire logic [DATA_W-1:0]    i_write_data,
    input  wire logic                 i_out_ready,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    output logic                      o_out_valid,
    output logic [BYTE_W-1:0]         o_tx_byte,
    output logic                      o_last_byte
);

    logic [BYTE_W-1:0]  r_node, n_node;
    logic [BYTE_W-1:0]  r_sync, n_sync;
    logic [FRAME_W-1:0] r_shift, n_shift;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0]  r_crc, n_crc;
    logic               r_write, n_write;
    logic               r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]  r_tx_byte, n_tx_byte;
    logic               r_last, n_last;

    logic               last;
    logic [BYTE_W-1:0]  cur_byte;

    // Select the byte for the current position: frame byte, or CRC at the end
    assign last     = (r_count == (r_write ? WRITE_LAST_IX : READ_LAST_IX));
    assign cur_byte = last ? r_crc : r_shift[FRAME_W-1 -: BYTE_W];

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.last     = last;

    // Update configuration
    always_comb begin
        n_node = r_node;
        n_sync = r_sync;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NODE_ADDRESS: n_node = i_cfg_data;
                CFG_SYNC_BYTE:    n_sync = i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Load the frame on a new request, advance one byte per emit
    always_comb begin
        n_shift     = r_shift;
        n_count     = r_count;
        n_crc       = r_crc;
        n_write     = r_write;
        n_out_valid = r_out_valid && !i_out_ready;
        n_tx_byte   = r_tx_byte;
        n_last      = r_last;
        if (i_cmd.load) begin
            n_write = (i_command == CMD_WRITE);
            n_shift = {r_sync, r_node, (i_command == CMD_WRITE), i_register_index,
                       i_write_data};
            n_count = '0;
            n_crc   = '0;
        end else if (i_cmd.emit) begin
            n_shift     = {r_shift[FRAME_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            n_count     = r_count + 1'b1;
            n_crc       = crc8_byte(r_crc, cur_byte);
            n_out_valid = 1'b1;
            n_tx_byte   = cur_byte;
            n_last      = last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node      <= NODE_RESET;
            r_sync      <= SYNC_RESET;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_write     <= 1'b0;
        end else begin
            r_node      <= n_node;
            r_sync      <= n_sync;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_write     <= n_write;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift   <= n_shift;
        r_crc     <= n_crc;
        r_tx_byte <= n_tx_byte;
        r_last    <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_last_byte = r_last;

`ifndef SYNTH
    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("byte emitted over an untaken output");
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_out_valid && r_last == $past(last)))
        else $error("emitted byte not presented");
    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_count == '0 && r_crc == '0))
        else $error("frame load did not clear counter and CRC");
`endif

endmodule

`default_nettype wire

>>> rtl/urdf_ctrl.sv
// Controller: two-state sequencer that takes a request and steps the datapath
// through the datagram bytes. Depends on urdf_pkg.
`default_nettype none

module urdf_ctrl
    import urdf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEND;
                end
            end
            ST_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.last) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after final byte");
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_SEND && !o_in_ready))
        else $error("request accepted without starting a datagram");
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.emit))
        else $error("load and emit in the same cycle");
`endif

endmodule

`default_nettype wire

>>> rtl/uart_register_datagram_framer.sv
// Flow: an accepted request is loaded into the datapath; the sequencer then moves each byte
// of the datagram into the output register, one byte per cycle while the output is free,
// and output stalls hold it. No request is taken mid-datagram; the next one is taken while the
// last byte waits. Reset: synchronous active low; clears sequencer and output valid, node
// address to 0, sync byte to 0x05. Depends on urdf_pkg, urdf_cmd_if, urdf_byte_if, urdf_ctrl,
// urdf_datapath.
`default_nettype none

module uart_register_datagram_framer
    import urdf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,
    urdf_cmd_if.sink                  i_cmd,
    urdf_byte_if.source               o_byte
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    assign i_cmd.ready = in_ready;

    urdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    urdf_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_cmd.command),
        .i_register_index (i_cmd.register_index),
        .i_write_data     (i_cmd.write_data),
        .i_out_ready      (o_byte.ready),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .o_out_valid      (o_byte.valid),
        .o_tx_byte        (o_byte.tx_byte),
        .o_last_byte      (o_byte.last_byte)
    );

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for uart_register_datagram_framer: drives read/write requests and
// checks every datagram byte and its last flag against a local framer and CRC-8 predictor.
// Depends on urdf_pkg, urdf_cmd_if, urdf_byte_if and the framer RTL.
`default_nettype none

module testbench;
    import urdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int READ_BYTES  = int'(READ_LAST_IX) + 1;
    localparam int WRITE_BYTES = int'(WRITE_LAST_IX) + 1;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 73;
    localparam int LONG_HOLD   = 80;
    localparam int SETTLE      = 10;

    // One byte of a datagram as it should leave the block
    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              last_byte;
    } t_frame_byte;

    typedef logic [WRITE_BYTES-1:0][BYTE_W-1:0] t_frame;

    // Directed request with the header bytes typed in by hand
    typedef struct {
        t_command             cmd;
        logic [REG_IDX_W-1:0] reg_ix;
        logic [DATA_W-1:0]    data;
        logic [BYTE_W-1:0]    sync_b;
        logic [BYTE_W-1:0]    node_b;
        logic [BYTE_W-1:0]    rw_b;
    } t_directed_req;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0]    i_cfg_data;

    urdf_cmd_if  cmd_ch ();
    urdf_byte_if byte_ch ();

    uart_register_datagram_framer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_ch),
        .o_byte     (byte_ch)
    );

    // Mirror of the configuration registers
    logic [BYTE_W-1:0] node_addr_cfg;
    logic [BYTE_W-1:0] sync_cfg;

    t_frame_byte datagram_q[$];
    int          error_count;
    bit          tx_no_idle;
    bit          rx_no_idle;
    bit          long_hold_req;

    // Clock: 8 ns period
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort a hung run
    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Fold one byte into the CRC-8, data bits taken least significant first
    function automatic logic [BYTE_W-1:0] crc8_fold(logic [BYTE_W-1:0] crc,
                                                    logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] acc;
        acc = crc;
        for (int k = 0; k < BYTE_W; k++) begin
            if (acc[BYTE_W-1] != b[k])
                acc = {acc[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                acc = {acc[BYTE_W-2:0], 1'b0};
        end
        return acc;
    endfunction

    // Assemble the datagram for one request under the current settings; return its length
    function automatic int build_datagram(t_command cmd, logic [REG_IDX_W-1:0] reg_ix,
                                          logic [DATA_W-1:0] data, output t_frame f);
        logic [BYTE_W-1:0] crc;
        int                len;
        len  = (cmd == CMD_WRITE) ? WRITE_BYTES : READ_BYTES;
        f    = '0;
        f[0] = sync_cfg;
        f[1] = node_addr_cfg;
        f[2] = {cmd == CMD_WRITE, reg_ix};
        if (cmd == CMD_WRITE) begin
            f[3] = data[31:24];
            f[4] = data[23:16];
            f[5] = data[15:8];
            f[6] = data[7:0];
        end
        crc = '0;
        for (int k = 0; k < len - 1; k++)
            crc = crc8_fold(crc, f[k]);
        f[len-1] = crc;
        return len;
    endfunction

    // Offer one request after a random gap; queue its bytes once accepted
    task automatic send_request(t_command cmd, logic [REG_IDX_W-1:0] reg_ix,
                                logic [DATA_W-1:0] data, bit typed,
                                logic [BYTE_W-1:0] sync_b, logic [BYTE_W-1:0] node_b,
                                logic [BYTE_W-1:0] rw_b);
        int     gap;
        int     len;
        t_frame f;
        gap = tx_no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.command        = cmd;
        cmd_ch.register_index = reg_ix;
        cmd_ch.write_data     = data;
        cmd_ch.valid          = 1'b1;
        do @(posedge i_clk); while (!cmd_ch.ready);
        len = build_datagram(cmd, reg_ix, data, f);
        if (typed) begin
            f[0] = sync_b;
            f[1] = node_b;
            f[2] = rw_b;
        end
        for (int k = 0; k < len; k++)
            datagram_q.push_back('{tx_byte: f[k], last_byte: (k == len - 1)});
        @(negedge i_clk);
    endtask

    // Random request, with the field extremes drawn often
    task automatic send_random();
        t_command             cmd;
        logic [REG_IDX_W-1:0] reg_ix;
        logic [DATA_W-1:0]    data;
        int                   sel;
        cmd = t_command'($urandom_range(0, 1));
        sel = $urandom_range(0, 9);
        reg_ix = (sel == 0) ? '0 : (sel == 1) ? '1 : REG_IDX_W'($urandom_range(0, 127));
        sel = $urandom_range(0, 9);
        data = (sel == 0) ? '0 : (sel == 1) ? '1 : DATA_W'($urandom);
        send_request(cmd, reg_ix, data, 1'b0, '0, '0, '0);
    endtask

    // Hold the request side until every queued byte is out, then let the block settle
    task automatic drain_and_settle();
        cmd_ch.valid = 1'b0;
        while (datagram_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Write one configuration register for a single cycle
    task automatic cfg_write(t_cfg_idx idx, logic [BYTE_W-1:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            CFG_NODE_ADDRESS: node_addr_cfg = value;
            CFG_SYNC_BYTE:    sync_cfg      = value;
            default: ;
        endcase
    endtask

    // Byte sink: random hold-off per byte, with no-stall stretches and one long stall
    initial begin : byte_sink
        int gap;
        byte_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                gap = LONG_HOLD;
            end else if (rx_no_idle) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 5);
            end
            if (gap > 0) begin
                byte_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            byte_ch.ready = 1'b1;
            do @(posedge i_clk); while (!byte_ch.valid);
            @(negedge i_clk);
        end
    end

    // Compare each accepted byte with the oldest expected one
    always @(posedge i_clk) begin : byte_check
        t_frame_byte want;
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            if (datagram_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                         $time, byte_ch.tx_byte, byte_ch.last_byte);
            end else begin
                want = datagram_q.pop_front();
                if (byte_ch.tx_byte !== want.tx_byte) begin
                    error_count++;
                    $display("%0t: tx_byte mismatch: expected %02h, actual %02h",
                             $time, want.tx_byte, byte_ch.tx_byte);
                end
                if (byte_ch.last_byte !== want.last_byte) begin
                    error_count++;
                    $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                             $time, want.last_byte, byte_ch.last_byte);
                end
            end
        end
    end

    // Directed requests at the reset settings: field extremes, both commands
    t_directed_req directed_reqs[] = '{
        '{CMD_READ,  7'h00, 32'hFFFF_FFFF, 8'h05, 8'h00, 8'h00},
        '{CMD_READ,  7'h7F, 32'h0000_0000, 8'h05, 8'h00, 8'h7F},
        '{CMD_WRITE, 7'h00, 32'h0000_0000, 8'h05, 8'h00, 8'h80},
        '{CMD_WRITE, 7'h7F, 32'hFFFF_FFFF, 8'h05, 8'h00, 8'hFF},
        '{CMD_WRITE, 7'h55, 32'hAAAA_AAAA, 8'h05, 8'h00, 8'hD5},
        '{CMD_WRITE, 7'h2A, 32'h5555_5555, 8'h05, 8'h00, 8'hAA},
        '{CMD_READ,  7'h55, 32'h5555_5555, 8'h05, 8'h00, 8'h55},
        '{CMD_READ,  7'h2A, 32'hAAAA_AAAA, 8'h05, 8'h00, 8'h2A},
        '{CMD_WRITE, 7'h01, 32'h8000_0000, 8'h05, 8'h00, 8'h81},
        '{CMD_WRITE, 7'h40, 32'h0000_0001, 8'h05, 8'h00, 8'hC0},
        '{CMD_WRITE, 7'h10, 32'h1234_5678, 8'h05, 8'h00, 8'h90},
        '{CMD_READ,  7'h01, 32'hDEAD_BEEF, 8'h05, 8'h00, 8'h01},
        '{CMD_WRITE, 7'h7F, 32'hFF00_FF00, 8'h05, 8'h00, 8'hFF},
        '{CMD_WRITE, 7'h00, 32'h00FF_00FF, 8'h05, 8'h00, 8'h80},
        '{CMD_READ,  7'h40, 32'h0000_0000, 8'h05, 8'h00, 8'h40}
    };

    initial begin : stimulus
        logic [BYTE_W-1:0] node_v;
        logic [BYTE_W-1:0] sync_v;

        // Drive every input to a known value and hold reset low before releasing it
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_NODE_ADDRESS;
        i_cfg_data            = '0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.command        = CMD_READ;
        cmd_ch.register_index = '0;
        cmd_ch.write_data     = '0;
        node_addr_cfg         = NODE_RESET;
        sync_cfg              = SYNC_RESET;
        error_count           = 0;
        tx_no_idle            = 1'b0;
        rx_no_idle            = 1'b0;
        long_hold_req         = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        foreach (directed_reqs[i])
            send_request(directed_reqs[i].cmd, directed_reqs[i].reg_ix,
                         directed_reqs[i].data, 1'b1, directed_reqs[i].sync_b,
                         directed_reqs[i].node_b, directed_reqs[i].rw_b);

        // Random phases, each under its own register settings
        for (int p = 0; p < PHASES; p++) begin
            drain_and_settle();
            case (p)
                0:       begin node_v = 8'hFF; sync_v = 8'hFF; end
                1:       begin node_v = 8'h00; sync_v = 8'h00; end
                3:       begin node_v = 8'h01; sync_v = 8'h80; end
                4:       begin node_v = 8'h80; sync_v = 8'h01; end
                default: begin
                    node_v = BYTE_W'($urandom);
                    sync_v = BYTE_W'($urandom);
                end
            endcase
            cfg_write(CFG_NODE_ADDRESS, node_v);
            cfg_write(CFG_SYNC_BYTE, sync_v);

            tx_no_idle = (p == 1);
            rx_no_idle = (p == 1);
            // Stall the byte side long enough to back up the request side
            if (p == 2) begin
                tx_no_idle    = 1'b1;
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Hold the request side until the block is empty once mid-phase
                if (p == 3 && n == PHASE_ITEMS / 2)
                    drain_and_settle();
                if ($urandom_range(0, 24) == 0)
                    tx_no_idle = ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 24) == 0)
                    rx_no_idle = ($urandom_range(0, 2) == 0);
                send_random();
            end
        end

        drain_and_settle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/urdf_pkg.sv
rtl/urdf_cmd_if.sv
rtl/urdf_byte_if.sv
rtl/urdf_datapath.sv
rtl/urdf_ctrl.sv
rtl/uart_register_datagram_framer.sv
test/testbench.sv
